/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent check macros used by the top-level RTL. They expand to nothing when
// the code is built for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define DSWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define DSWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define DSWS_ASSERT_IMP(lbl, ante, cons)
`define DSWS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* src/dsws_pkg.sv */
// ---------------------------------------------------------------------------
// dsws_pkg
// Widths, limits, register indexes and shared types of the delayed
// sliding-window statistics block.
// ---------------------------------------------------------------------------
package dsws_pkg;

  localparam int SAMPLE_W = 24;
  localparam int LEN_W    = 12;
  localparam int DLY_W    = 11;
  localparam int CNT_W    = 13;
  localparam int SUM_W    = 36;
  localparam int SQS_W    = 58;
  localparam int PROD_W   = 48;
  localparam int VAR_W    = 47;
  localparam int STD_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [LEN_W-1:0]   LEN_RESET = 12'd24;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 13'h1FFF;
  localparam logic [SQS_W-1:0]   VAR_MAX   = 58'h7FFF_FFFF_FFFF;
  localparam logic [SQS_W-1:0]   MEAN_POS_LIM = 58'h7F_FFFF;
  localparam logic [SQS_W-1:0]   MEAN_NEG_LIM = 58'h80_0000;
  localparam logic [SAMPLE_W-1:0] MEAN_MAX = 24'h7F_FFFF;
  localparam logic [SAMPLE_W-1:0] MEAN_MIN = 24'h80_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_DELAY  = 2'd1;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* src/dsws_in_if.sv */
// ---------------------------------------------------------------------------
// dsws_in_if
// Sample channel: one three-axis position sample per transaction.
// ---------------------------------------------------------------------------
interface dsws_in_if;
  import dsws_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  logic signed [SAMPLE_W-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink (input valid, input sample_x, input sample_y, input sample_z,
                output ready);
endinterface

/* src/dsws_out_if.sv */
// ---------------------------------------------------------------------------
// dsws_out_if
// Statistics channel: one result per accepted sample.
// ---------------------------------------------------------------------------
interface dsws_out_if;
  import dsws_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       stats_valid;
  logic [LEN_W-1:0]           fill_count;
  logic signed [SAMPLE_W-1:0] mean_x;
  logic signed [SAMPLE_W-1:0] mean_y;
  logic signed [SAMPLE_W-1:0] mean_z;
  logic [VAR_W-1:0]           var_x;
  logic [VAR_W-1:0]           var_y;
  logic [VAR_W-1:0]           var_z;
  logic [STD_W-1:0]           std_x;
  logic [STD_W-1:0]           std_y;
  logic [STD_W-1:0]           std_z;

  modport source (output valid, output stats_valid, output fill_count,
                  output mean_x, output mean_y, output mean_z,
                  output var_x, output var_y, output var_z,
                  output std_x, output std_y, output std_z, input ready);
  modport sink (input valid, input stats_valid, input fill_count,
                input mean_x, input mean_y, input mean_z,
                input var_x, input var_y, input var_z,
                input std_x, input std_y, input std_z, output ready);
endinterface

/* src/dsws_cfg_if.sv */
// ---------------------------------------------------------------------------
// dsws_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface dsws_cfg_if;
  import dsws_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/delayed_sliding_window_stats.sv */
// ---------------------------------------------------------------------------
// delayed_sliding_window_stats
// Delayed sliding-window mean, variance and standard deviation over a
// three-axis position stream, kept as running sums over a sample ring.
//
//   channel  | dir | payload
//   in_ch    | in  | sample_x, sample_y, sample_z
//   out_ch   | out | stats_valid, fill_count, mean_*, var_*, std_*
//   cfg_ch   | in  | index (0 window_length, 1 window_delay), data
//
// Samples are handled one at a time, axis by axis, through the shared
// bit-serial divider, which runs twice per axis (mean, then square sum),
// and the serial square root. Ring offsets beyond RING_DEPTH are reduced
// by repeated subtraction of the depth. Reset is synchronous and clears
// counters, sums and the window; the ring holds no reset. A new sample
// is taken while a finished result waits in the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module delayed_sliding_window_stats #(
  parameter int RING_DEPTH = 4096,
  parameter int AXIS_COUNT = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  dsws_in_if.sink    in_ch,
  dsws_out_if.source out_ch,
  dsws_cfg_if.sink   cfg_ch
);
  import dsws_pkg::*;

  localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int OFF_W = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int AXW   = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int RW    = AXIS_COUNT * SAMPLE_W;
  localparam logic [OFF_W-1:0] DEPTH_C = OFF_W'(RING_DEPTH);
  localparam int AX_MAX_C = 3;

  typedef enum logic [3:0] {
    S_IDLE, S_RED_N, S_RD_N, S_LAT_N, S_RED_O, S_RD_O, S_LAT_O,
    S_SQN, S_SQO, S_SQD, S_DIVM, S_DIVS, S_SQRT, S_PUB
  } state_t;

  // Control state.
  state_t           st_r;
  logic [AW-1:0]    ptr_r;
  logic [CNT_W-1:0] wcnt_r;
  logic             seen_r;
  logic [LEN_W-1:0] fill_r;
  logic             full_r;
  logic [LEN_W-1:0] len_r;
  logic [DLY_W-1:0] dly_r;
  logic [LEN_W-1:0] leff_r;
  logic [OFF_W-1:0] off_r;
  logic [AW-1:0]    base_r;
  logic [AW-1:0]    addr_r;
  logic [AXW-1:0]   ax_r;
  logic             out_v_r;
  logic [SUM_W-1:0] sum_r [AXIS_COUNT];
  logic [SQS_W-1:0] sqs_r [AXIS_COUNT];

  // Data path registers.
  logic [RW-1:0]              ring [RING_DEPTH];
  logic [RW-1:0]              rdata_r;
  logic [RW-1:0]              new_r;
  logic [RW-1:0]              old_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic                       neg_r;
  logic signed [SAMPLE_W-1:0] res_mean_r [AXIS_COUNT];
  logic [VAR_W-1:0]           res_var_r  [AXIS_COUNT];
  logic [STD_W-1:0]           res_std_r  [AXIS_COUNT];
  logic                       out_stats_r;
  logic [LEN_W-1:0]           out_fill_r;
  logic signed [SAMPLE_W-1:0] out_mean_r [AX_MAX_C];
  logic [VAR_W-1:0]           out_var_r  [AX_MAX_C];
  logic [STD_W-1:0]           out_std_r  [AX_MAX_C];

  // Combinational signals.
  logic                       in_acc;
  logic                       pub_go;
  logic [RW-1:0]              wdata;
  logic [CNT_W-1:0]           wcnt_nxt;
  logic                       seen_nxt;
  logic [LEN_W-1:0]           len_eff;
  logic [OFF_W-1:0]           base_ext;
  logic [OFF_W-1:0]           back_idx;
  logic signed [SAMPLE_W-1:0] nv;
  logic signed [SAMPLE_W-1:0] ov;
  logic signed [SAMPLE_W-1:0] mul_op;
  logic [SUM_W-1:0]           sum_cur;
  logic [SUM_W-1:0]           sum_mag;
  logic                       div_start;
  logic [SQS_W-1:0]           div_dvd;
  logic [SQS_W-1:0]           div_q;
  unit_stat_t                 div_stat;
  logic signed [SAMPLE_W-1:0] mean_sat;
  logic [SQS_W-1:0]           msq;
  logic [SQS_W-1:0]           var_diff;
  logic [VAR_W-1:0]           var_val;
  logic                       sqrt_start;
  logic [STD_W-1:0]           sqrt_root;
  unit_stat_t                 sqrt_stat;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign pub_go       = (st_r == S_PUB) && (!out_v_r || out_ch.ready);

  // Sample word, count and window bookkeeping for the incoming sample.
  always_comb begin
    for (int i = 0; i < AXIS_COUNT; i++) begin
      case (i)
        0:       wdata[i*SAMPLE_W +: SAMPLE_W] = in_ch.sample_x;
        1:       wdata[i*SAMPLE_W +: SAMPLE_W] = in_ch.sample_y;
        default: wdata[i*SAMPLE_W +: SAMPLE_W] = in_ch.sample_z;
      endcase
    end
    wcnt_nxt = (wcnt_r == CNT_MAX) ? wcnt_r : wcnt_r + 1'b1;
    seen_nxt = (wcnt_nxt > CNT_W'(dly_r));
    len_eff  = (len_r == '0) ? LEN_W'(1) : len_r;
  end

  // Ring index that lies off_r places behind base_r, once off_r < depth.
  always_comb begin
    base_ext = OFF_W'(base_r);
    back_idx = (base_ext >= off_r) ? (base_ext - off_r) : (base_ext + DEPTH_C - off_r);
  end

  // Per-axis operands.
  always_comb begin
    nv      = new_r[ax_r*SAMPLE_W +: SAMPLE_W];
    ov      = old_r[ax_r*SAMPLE_W +: SAMPLE_W];
    sum_cur = sum_r[ax_r];
    sum_mag = sum_cur[SUM_W-1] ? (~sum_cur + 1'b1) : sum_cur;
    case (st_r)
      S_SQN:   mul_op = nv;
      S_SQO:   mul_op = ov;
      default: mul_op = mean_r;
    endcase
  end

  // Divider feeds: first |sum| for the mean, then the square sum.
  assign div_start = (st_r == S_SQD) || ((st_r == S_DIVM) && div_stat.done);
  assign div_dvd   = (st_r == S_SQD) ? SQS_W'(sum_mag) : sqs_r[ax_r];

  dsws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (fill_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // Mean with sign restored and saturated; variance clamped both ways.
  always_comb begin
    if (!neg_r) begin
      mean_sat = (div_q > MEAN_POS_LIM) ? MEAN_MAX : div_q[SAMPLE_W-1:0];
    end else begin
      mean_sat = (div_q > MEAN_NEG_LIM) ? MEAN_MIN : (~div_q[SAMPLE_W-1:0] + 1'b1);
    end
    msq      = SQS_W'(unsigned'(prod_r));
    var_diff = div_q - msq;
    if (div_q <= msq) begin
      var_val = '0;
    end else if (var_diff > VAR_MAX) begin
      var_val = VAR_MAX[VAR_W-1:0];
    end else begin
      var_val = var_diff[VAR_W-1:0];
    end
  end

  assign sqrt_start = (st_r == S_DIVS) && div_stat.done;

  dsws_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (var_val),
    .root     (sqrt_root),
    .stat     (sqrt_stat)
  );

  // Sample ring: written on accept, read in the cycle after the address.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring[ptr_r] <= wdata;
    end
    rdata_r <= ring[addr_r];
  end

  // Sequencer, counters, running sums and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      ptr_r   <= '0;
      wcnt_r  <= '0;
      seen_r  <= 1'b0;
      fill_r  <= '0;
      full_r  <= 1'b0;
      len_r   <= LEN_RESET;
      dly_r   <= '0;
      leff_r  <= LEN_W'(1);
      off_r   <= '0;
      base_r  <= '0;
      addr_r  <= '0;
      ax_r    <= '0;
      out_v_r <= 1'b0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        sum_r[i] <= '0;
        sqs_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == CFG_WINDOW_LENGTH) begin
          len_r <= cfg_ch.data[LEN_W-1:0];
        end else if (cfg_ch.index == CFG_WINDOW_DELAY) begin
          dly_r <= cfg_ch.data[DLY_W-1:0];
        end
      end
      if (out_v_r && out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            ptr_r  <= (ptr_r == AW'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
            wcnt_r <= wcnt_nxt;
            seen_r <= seen_nxt;
            base_r <= ptr_r;
            off_r  <= OFF_W'(dly_r);
            leff_r <= len_eff;
            ax_r   <= '0;
            if (seen_nxt) begin
              full_r <= (fill_r >= len_eff);
              fill_r <= (fill_r >= len_eff) ? len_eff : fill_r + 1'b1;
              st_r   <= S_RED_N;
            end else begin
              st_r <= S_PUB;
            end
          end
        end
        S_RED_N: begin
          if (off_r >= DEPTH_C) begin
            off_r <= off_r - DEPTH_C;
          end else begin
            addr_r <= back_idx[AW-1:0];
            base_r <= back_idx[AW-1:0];
            st_r   <= S_RD_N;
          end
        end
        S_RD_N: st_r <= S_LAT_N;
        S_LAT_N: begin
          off_r <= OFF_W'(leff_r);
          st_r  <= S_RED_O;
        end
        S_RED_O: begin
          if (off_r >= DEPTH_C) begin
            off_r <= off_r - DEPTH_C;
          end else begin
            addr_r <= back_idx[AW-1:0];
            st_r   <= S_RD_O;
          end
        end
        S_RD_O: st_r <= S_LAT_O;
        S_LAT_O: st_r <= S_SQN;
        S_SQN: begin
          sum_r[ax_r] <= sum_r[ax_r] + SUM_W'(nv) - SUM_W'(ov);
          st_r        <= S_SQO;
        end
        S_SQO: begin
          sqs_r[ax_r] <= sqs_r[ax_r] + SQS_W'(unsigned'(prod_r));
          st_r        <= S_SQD;
        end
        S_SQD: begin
          sqs_r[ax_r] <= sqs_r[ax_r] - SQS_W'(unsigned'(prod_r));
          st_r        <= S_DIVM;
        end
        S_DIVM: begin
          if (div_stat.done) begin
            st_r <= S_DIVS;
          end
        end
        S_DIVS: begin
          if (div_stat.done) begin
            st_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_stat.done) begin
            if (ax_r == AXW'(AXIS_COUNT - 1)) begin
              st_r <= S_PUB;
            end else begin
              ax_r <= ax_r + 1'b1;
              st_r <= S_SQN;
            end
          end
        end
        S_PUB: begin
          if (pub_go) begin
            out_v_r <= 1'b1;
            st_r    <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Data path: operands, products, per-axis results and the output register.
  always_ff @(posedge clk) begin
    prod_r <= mul_op * mul_op;
    if (in_acc) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        res_mean_r[i] <= '0;
        res_var_r[i]  <= '0;
        res_std_r[i]  <= '0;
      end
    end
    if (st_r == S_LAT_N) begin
      new_r <= rdata_r;
    end
    if (st_r == S_LAT_O) begin
      old_r <= full_r ? rdata_r : '0;
    end
    if (st_r == S_SQD) begin
      neg_r <= sum_cur[SUM_W-1];
    end
    if ((st_r == S_DIVM) && div_stat.done) begin
      mean_r <= mean_sat;
    end
    if (sqrt_start) begin
      res_mean_r[ax_r] <= mean_r;
      res_var_r[ax_r]  <= var_val;
    end
    if ((st_r == S_SQRT) && sqrt_stat.done) begin
      res_std_r[ax_r] <= sqrt_root;
    end
    if (pub_go) begin
      out_stats_r <= seen_r;
      out_fill_r  <= fill_r;
      for (int i = 0; i < AX_MAX_C; i++) begin
        if (i < AXIS_COUNT) begin
          out_mean_r[i] <= res_mean_r[i];
          out_var_r[i]  <= res_var_r[i];
          out_std_r[i]  <= res_std_r[i];
        end else begin
          out_mean_r[i] <= '0;
          out_var_r[i]  <= '0;
          out_std_r[i]  <= '0;
        end
      end
    end
  end

  // Result channel.
  assign out_ch.valid       = out_v_r;
  assign out_ch.stats_valid = out_stats_r;
  assign out_ch.fill_count  = out_fill_r;
  assign out_ch.mean_x      = out_mean_r[0];
  assign out_ch.mean_y      = out_mean_r[1];
  assign out_ch.mean_z      = out_mean_r[2];
  assign out_ch.var_x       = out_var_r[0];
  assign out_ch.var_y       = out_var_r[1];
  assign out_ch.var_z       = out_var_r[2];
  assign out_ch.std_x       = out_std_r[0];
  assign out_ch.std_y       = out_std_r[1];
  assign out_ch.std_z       = out_std_r[2];

  // A publish always leaves a result transaction waiting next cycle.
  `DSWS_ASSERT_NEXT(a_pub_shows, pub_go, out_v_r)
  // A valid window never divides by an empty count.
  `DSWS_ASSERT_IMP(a_fill_nonzero, out_v_r && out_stats_r, out_fill_r != '0)
  // The divider is never restarted in the middle of a run.
  `DSWS_ASSERT_IMP(a_div_idle, div_start, !div_stat.busy)
  // The axis counter stays within the configured axes.
  `DSWS_ASSERT_IMP(a_axis_range, st_r == S_SQN, ax_r <= AXW'(AXIS_COUNT - 1))
endmodule

/* src/dsws_div.sv */
// ---------------------------------------------------------------------------
// dsws_div
// Bit-serial restoring divider: 58-bit unsigned dividend by a 12-bit
// divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dsws_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dsws_pkg::SQS_W-1:0] dividend,
  input  logic [dsws_pkg::LEN_W-1:0] divisor,
  output logic [dsws_pkg::SQS_W-1:0] quotient,
  output dsws_pkg::unit_stat_t       stat
);
  import dsws_pkg::*;

  localparam int STEP_W = $clog2(SQS_W);

  logic [SQS_W-1:0]  dvd_r;
  logic [LEN_W-1:0]  dsr_r;
  logic [LEN_W-1:0]  rem_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [LEN_W:0]    shifted;
  logic              qbit;
  logic [LEN_W:0]    rem_nxt;

  // One restoring step: shift in the next dividend bit and try the divisor.
  always_comb begin
    shifted = {rem_r, dvd_r[SQS_W-1]};
    qbit    = (shifted >= {1'b0, dsr_r});
    rem_nxt = qbit ? (shifted - {1'b0, dsr_r}) : shifted;
  end

  // Control: a run lasts one cycle per dividend bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(SQS_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Data path: quotient bits enter where dividend bits leave.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[SQS_W-2:0], qbit};
      rem_r <= rem_nxt[LEN_W-1:0];
    end
  end

  assign quotient  = dvd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

/* src/dsws_sqrt.sv */
// ---------------------------------------------------------------------------
// dsws_sqrt
// Digit-serial integer square root: one root bit per cycle over a 47-bit
// radicand, giving the floor of the root.
// ---------------------------------------------------------------------------
module dsws_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dsws_pkg::VAR_W-1:0] radicand,
  output logic [dsws_pkg::STD_W-1:0] root,
  output dsws_pkg::unit_stat_t       stat
);
  import dsws_pkg::*;

  localparam int RAD_W  = 2 * STD_W;
  localparam int REM_W  = STD_W + 2;
  localparam int STEP_W = $clog2(STD_W);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [STD_W-1:0]  root_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              take;
  logic [REM_W+1:0]  rem_nxt;

  // Bring down the next two radicand bits and try 4*root + 1.
  always_comb begin
    rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    take    = (rem_sh >= trial);
    rem_nxt = take ? (rem_sh - trial) : rem_sh;
  end

  // Control: one cycle per root bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(STD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Data path.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {{(RAD_W - VAR_W){1'b0}}, radicand};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt[REM_W-1:0];
      root_r <= {root_r[STD_W-2:0], take};
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives three-axis position samples into the delayed sliding-window
// statistics block under several window settings and random stalls on both
// channels. Each result is checked field by field against an in-bench
// model of the running sums, mean, variance and square root.
// ---------------------------------------------------------------------------
module testbench;
  import dsws_pkg::*;

  localparam int RING_SLOTS = 4096;
  localparam int AXES       = 3;
  localparam int SETTLE     = 600;

  typedef struct {
    logic              ready_flag;
    logic [LEN_W-1:0]  fill;
    logic [SAMPLE_W-1:0] mean[AXES];
    logic [VAR_W-1:0]  variance[AXES];
    logic [STD_W-1:0]  sdev[AXES];
  } stats_t;

  typedef struct {
    bit                  reconfig;
    logic [LEN_W-1:0]    len;
    logic [DLY_W-1:0]    dly;
    logic [SAMPLE_W-1:0] sx, sy, sz;
    bit                  literal;
  } row_t;

  logic clk;
  logic rst_n;

  dsws_in_if  in_bus();
  dsws_out_if out_bus();
  dsws_cfg_if cfg_bus();

  delayed_sliding_window_stats dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Model state of the window.
  logic signed [SAMPLE_W-1:0] model_ring[RING_SLOTS][AXES];
  int unsigned                model_wr_ptr;
  int unsigned                model_wr_count;
  int unsigned                model_fill;
  logic [SUM_W-1:0]           model_sum[AXES];
  logic [SQS_W-1:0]           model_sqsum[AXES];
  logic [LEN_W-1:0]           model_len;
  logic [DLY_W-1:0]           model_dly;

  stats_t pending_stats[$];
  int     error_count;
  int     results_seen;
  int     samples_sent;
  int     settings_used;
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     hold_req;
  int     hold_left;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Floor square root by bitwise search.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // Advance the window by one sample and return the statistics it yields.
  function automatic stats_t window_update(input logic [SAMPLE_W-1:0] sx,
                                           input logic [SAMPLE_W-1:0] sy,
                                           input logic [SAMPLE_W-1:0] sz);
    stats_t      r;
    int unsigned p, inew, iold, len_eff;
    bit          full;
    longint      nv, ov, mean, msq, total;
    logic [63:0] ms, vr;
    p = model_wr_ptr;
    model_ring[p][0] = sx;
    model_ring[p][1] = sy;
    model_ring[p][2] = sz;
    model_wr_ptr = (p + 1) % RING_SLOTS;
    if (model_wr_count < CNT_MAX) model_wr_count++;
    r.ready_flag = (model_wr_count > model_dly);
    for (int a = 0; a < AXES; a++) begin
      r.mean[a] = '0;
      r.variance[a] = '0;
      r.sdev[a] = '0;
    end
    if (r.ready_flag) begin
      len_eff = (model_len == 0) ? 1 : model_len;
      inew = (p + RING_SLOTS - (model_dly % RING_SLOTS)) % RING_SLOTS;
      iold = (inew + RING_SLOTS - (len_eff % RING_SLOTS)) % RING_SLOTS;
      full = (model_fill >= len_eff);
      model_fill = full ? len_eff : model_fill + 1;
      for (int a = 0; a < AXES; a++) begin
        nv = model_ring[inew][a];
        ov = full ? longint'(model_ring[iold][a]) : 0;
        model_sum[a] = model_sum[a] + SUM_W'(nv) - SUM_W'(ov);
        model_sqsum[a] = model_sqsum[a] + SQS_W'(nv * nv) - SQS_W'(ov * ov);
        total = $signed(model_sum[a]);
        mean = total / longint'(model_fill);
        if (mean > 64'sd8388607) mean = 64'sd8388607;
        if (mean < -64'sd8388608) mean = -64'sd8388608;
        msq = mean * mean;
        ms = {6'd0, model_sqsum[a]} / 64'(model_fill);
        vr = (ms > 64'(msq)) ? ms - 64'(msq) : 64'd0;
        if (vr > 64'h7FFF_FFFF_FFFF) vr = 64'h7FFF_FFFF_FFFF;
        r.mean[a] = mean[SAMPLE_W-1:0];
        r.variance[a] = vr[VAR_W-1:0];
        r.sdev[a] = STD_W'(floor_sqrt(vr));
      end
    end
    r.fill = model_fill[LEN_W-1:0];
    return r;
  endfunction

  // Largest delay that never makes the window reach an unwritten ring slot.
  function automatic int unsigned safe_delay_max(input logic [LEN_W-1:0] len);
    int unsigned len_eff, need, lim;
    len_eff = (len == 0) ? 1 : len;
    need = (model_fill < len_eff) ? model_fill : len_eff;
    if (need == 0) return 2047;
    lim = model_wr_count - need;
    return (lim > 2047) ? 2047 : lim;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 3000;
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report(input string name, input logic [63:0] exp_v,
                        input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Result monitor: compare each accepted transaction with the oldest expectation.
  always @(posedge clk) begin
    stats_t exp_s;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (pending_stats.size() == 0) begin
        error_count++;
        $display("%0t: result transaction with no expectation waiting", $time);
      end else begin
        exp_s = pending_stats.pop_front();
        report("stats_valid", 64'(exp_s.ready_flag), 64'(out_bus.stats_valid));
        report("fill_count", 64'(exp_s.fill), 64'(out_bus.fill_count));
        report("mean_x", 64'(exp_s.mean[0]), 64'(unsigned'(out_bus.mean_x)));
        report("mean_y", 64'(exp_s.mean[1]), 64'(unsigned'(out_bus.mean_y)));
        report("mean_z", 64'(exp_s.mean[2]), 64'(unsigned'(out_bus.mean_z)));
        report("var_x", 64'(exp_s.variance[0]), 64'(out_bus.var_x));
        report("var_y", 64'(exp_s.variance[1]), 64'(out_bus.var_y));
        report("var_z", 64'(exp_s.variance[2]), 64'(out_bus.var_z));
        report("std_x", 64'(exp_s.sdev[0]), 64'(out_bus.std_x));
        report("std_y", 64'(exp_s.sdev[1]), 64'(out_bus.std_y));
        report("std_z", 64'(exp_s.sdev[2]), 64'(out_bus.std_z));
      end
    end
  end

  // Wait until every expected result has been returned.
  task automatic drain_results();
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    if (idx == CFG_WINDOW_LENGTH) model_len = value[LEN_W-1:0];
    else if (idx == CFG_WINDOW_DELAY) model_dly = value[DLY_W-1:0];
  endtask

  task automatic set_window(input logic [LEN_W-1:0] len, input logic [DLY_W-1:0] dly);
    drain_results();
    write_reg(CFG_WINDOW_LENGTH, len);
    write_reg(CFG_WINDOW_DELAY, CFG_DATA_W'(dly));
    settings_used++;
  endtask

  // Offer one sample; on acceptance queue its expectation.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sx,
                             input logic [SAMPLE_W-1:0] sy,
                             input logic [SAMPLE_W-1:0] sz,
                             input bit literal);
    stats_t s;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.sample_x <= sx;
    in_bus.sample_y <= sy;
    in_bus.sample_z <= sz;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    s = window_update(sx, sy, sz);
    if (literal) begin
      // Not yet valid: everything reads zero and the window is still empty.
      s.ready_flag = 1'b0;
      s.fill = '0;
      for (int a = 0; a < AXES; a++) begin
        s.mean[a] = '0;
        s.variance[a] = '0;
        s.sdev[a] = '0;
      end
    end
    pending_stats.push_back(s);
    samples_sent++;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample(input int mode,
                                                       input logic [SAMPLE_W-1:0] base);
    case (mode)
      0: return SAMPLE_W'($urandom);
      1: return SAMPLE_W'($urandom_range(2000)) - SAMPLE_W'(1000);
      2: return $urandom_range(1) ? MEAN_MAX : MEAN_MIN;
      default: return base + SAMPLE_W'($urandom_range(512)) - SAMPLE_W'(256);
    endcase
  endfunction

  // Directed rows: extremes, bit patterns, lengths of zero, two and 2048, delay extremes.
  row_t directed[15] = '{
    '{1, 12'd0,    11'd2047, 24'h7FFFFF, 24'h800000, 24'h000000, 1},
    '{0, 12'd0,    11'd0,    24'h800000, 24'h7FFFFF, 24'hFFFFFF, 1},
    '{0, 12'd0,    11'd0,    24'h000000, 24'h000001, 24'h555555, 1},
    '{1, 12'd0,    11'd2,    24'hFFFFFF, 24'hAAAAAA, 24'h7FFFFF, 0},
    '{0, 12'd0,    11'd0,    24'h000001, 24'h555555, 24'h800000, 0},
    '{0, 12'd0,    11'd0,    24'h555555, 24'h000000, 24'hAAAAAA, 0},
    '{0, 12'd0,    11'd0,    24'hAAAAAA, 24'h7FFFFF, 24'h000001, 0},
    '{0, 12'd0,    11'd0,    24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0},
    '{1, 12'd2,    11'd0,    24'h800000, 24'h800000, 24'h800000, 0},
    '{0, 12'd0,    11'd0,    24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0},
    '{0, 12'd0,    11'd0,    24'h800000, 24'h800000, 24'h800000, 0},
    '{0, 12'd0,    11'd0,    24'h7FFFFF, 24'h800000, 24'h000000, 0},
    '{1, 12'd2048, 11'd1,    24'h123456, 24'hFEDCBA, 24'h000000, 0},
    '{0, 12'd0,    11'd0,    24'h000005, 24'hFFFFFB, 24'h000000, 0},
    '{0, 12'd0,    11'd0,    24'h7FFFFF, 24'h800000, 24'hFFFFFF, 0}
  };

  // Stimulus and end of run.
  initial begin
    int                  phase_items, mode, pick, sent_random;
    int unsigned         dmax;
    logic [LEN_W-1:0]    len;
    logic [DLY_W-1:0]    dly;
    logic [SAMPLE_W-1:0] base[AXES];

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.sample_x = '0;
    in_bus.sample_y = '0;
    in_bus.sample_z = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    out_bus.ready = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    error_count = 0;
    results_seen = 0;
    samples_sent = 0;
    settings_used = 0;
    send_idle_pct = 36;
    recv_idle_pct = 48;
    model_wr_ptr = 0;
    model_wr_count = 0;
    model_fill = 0;
    model_len = LEN_RESET;
    model_dly = '0;
    for (int a = 0; a < AXES; a++) begin
      model_sum[a] = '0;
      model_sqsum[a] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part; the sender goes quiet before each window change.
    foreach (directed[i]) begin
      if (directed[i].reconfig) begin
        in_bus.valid <= 1'b0;
        set_window(directed[i].len, directed[i].dly);
      end
      send_sample(directed[i].sx, directed[i].sy, directed[i].sz, directed[i].literal);
    end
    in_bus.valid <= 1'b0;

    // Random part: a new window setting per phase, idling regime by progress.
    sent_random = 0;
    for (int ph = 0; ph < 8; ph++) begin
      pick = $urandom_range(7);
      case (pick)
        0: len = 12'd1;
        1: len = 12'd2048;
        2: len = 12'd0;
        3: len = 12'd2047;
        default: len = LEN_W'($urandom_range(40, 2));
      endcase
      if (ph == 7) len = 12'd4;
      dmax = safe_delay_max(len);
      case ($urandom_range(2))
        0: dly = '0;
        1: dly = DLY_W'(dmax);
        default: dly = DLY_W'($urandom_range(dmax));
      endcase
      set_window(len, dly);
      if (ph == 2) hold_req = 1'b1;
      for (int a = 0; a < AXES; a++) base[a] = SAMPLE_W'($urandom);
      phase_items = 81;
      for (int k = 0; k < phase_items; k++) begin
        if (sent_random < 216) begin
          send_idle_pct = 36;
          recv_idle_pct = 48;
        end else if (sent_random < 432) begin
          send_idle_pct = 48;
          recv_idle_pct = 36;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        mode = $urandom_range(5);
        send_sample(random_sample(mode, base[0]), random_sample(mode, base[1]),
                    random_sample(mode, base[2]), 1'b0);
        sent_random++;
      end
      in_bus.valid <= 1'b0;
    end

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d samples and %0d results over %0d window settings,",
             samples_sent, results_seen, settings_used);
    $display("with stalls on both channels and one long output hold-off.");
    if (error_count == 0 && pending_stats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #60_000_000;
    $display("Timeout with %0d results outstanding", pending_stats.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
